### hdl/srt_pkg.sv
// shared types and constants for the shortest remaining time scheduler
package srt_pkg;

  localparam int unsigned SLOTS  = 16;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned TIME_W = 32;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned PID_W  = 5;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_RAN    = 3'd0,
    ST_IDLE   = 3'd1,
    ST_LOADED = 3'd2,
    ST_FULL   = 3'd3,
    ST_ZERO   = 3'd4
  } status_e;

  typedef struct packed {
    logic               kind;
    logic [TIME_W-1:0]  arrival_time;
    logic [BURST_W-1:0] burst_length;
  } srt_in_t;

  typedef struct packed {
    status_e            status;
    logic [TIME_W-1:0]  tick_time;
    logic [PID_W-1:0]   process_id;
    logic               finished;
    logic               all_done;
  } srt_out_t;

endpackage

### hdl/shortest_remaining_time_scheduler.sv
// top level of the shortest remaining time first scheduler
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------
//  input   | in        | in_valid_i / in_ready_o    | srt_pkg::srt_in_t
//  output  | out       | out_valid_o / out_ready_i  | srt_pkg::srt_out_t
//
// a load passes through the load step; a tick passes through the scan step and then the update step
// a tick scans the loaded entries of the slot table one entry a cycle through a single compare unit
// one transaction at a time; the next one is taken while the result waits
// reset clears counters, time and completion flags; slot memories need no clearing
// a stalled output holds the sequencer in its last step until the result is taken
module shortest_remaining_time_scheduler (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  srt_pkg::srt_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output srt_pkg::srt_out_t out_data_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_SCAN = 4'b0100,
    S_UPD  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  srt_pkg::srt_in_t                 item_q, item_d;
  logic [srt_pkg::TIME_W-1:0]       now_q, now_d;
  logic [srt_pkg::CNT_W-1:0]        loaded_q, loaded_d;
  logic [srt_pkg::CNT_W-1:0]        done_cnt_q, done_cnt_d;
  logic [srt_pkg::SLOTS-1:0]        done_q, done_d;
  logic [srt_pkg::CNT_W-1:0]        idx_q, idx_d;
  logic                             rd_v_q, rd_v_d;
  logic [srt_pkg::SLOT_W-1:0]       rd_idx_q, rd_idx_d;
  logic                             found_q, found_d;
  logic [srt_pkg::SLOT_W-1:0]       best_q, best_d;
  logic [srt_pkg::BURST_W-1:0]      best_rem_q, best_rem_d;
  logic                             out_valid_q, out_valid_d;
  srt_pkg::srt_out_t                out_q, out_d;

  logic                             arr_we, rem_we;
  logic [srt_pkg::SLOT_W-1:0]       rem_waddr, rd_addr;
  logic [srt_pkg::BURST_W-1:0]      rem_wdata, rem_new;
  logic [srt_pkg::TIME_W-1:0]       arr_rd;
  logic [srt_pkg::BURST_W-1:0]      rem_rd;
  logic                             out_free, issue, eligible, fin;

  srt_ram #(
    .WIDTH(srt_pkg::TIME_W),
    .DEPTH(srt_pkg::SLOTS)
  ) u_arr_ram (
    .clk_i  (clk_i),
    .we_i   (arr_we),
    .waddr_i(loaded_q[srt_pkg::SLOT_W-1:0]),
    .wdata_i(item_q.arrival_time),
    .raddr_i(rd_addr),
    .rdata_o(arr_rd)
  );

  srt_ram #(
    .WIDTH(srt_pkg::BURST_W),
    .DEPTH(srt_pkg::SLOTS)
  ) u_rem_ram (
    .clk_i  (clk_i),
    .we_i   (rem_we),
    .waddr_i(rem_waddr),
    .wdata_i(rem_wdata),
    .raddr_i(rd_addr),
    .rdata_o(rem_rd)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign issue       = (idx_q < loaded_q);
  assign rd_addr     = idx_q[srt_pkg::SLOT_W-1:0];
  assign eligible    = !done_q[rd_idx_q] && (arr_rd <= now_q);
  assign rem_new     = (best_rem_q != '0) ? best_rem_q - 1'b1 : best_rem_q;
  assign fin         = found_q && (rem_new == '0);

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    now_d       = now_q;
    loaded_d    = loaded_q;
    done_cnt_d  = done_cnt_q;
    done_d      = done_q;
    idx_d       = idx_q;
    rd_v_d      = 1'b0;
    rd_idx_d    = rd_idx_q;
    found_d     = found_q;
    best_d      = best_q;
    best_rem_d  = best_rem_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    arr_we      = 1'b0;
    rem_we      = 1'b0;
    rem_waddr   = best_q;
    rem_wdata   = rem_new;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          idx_d   = '0;
          found_d = 1'b0;
          state_d = (in_data_i.kind == srt_pkg::KIND_TICK) ? S_SCAN : S_LOAD;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.tick_time   = now_q;
          out_d.finished    = 1'b0;
          out_d.process_id  = '0;
          if (loaded_q == srt_pkg::CNT_W'(srt_pkg::SLOTS)) begin
            out_d.status = srt_pkg::ST_FULL;
          end else if (item_q.burst_length == '0) begin
            out_d.status = srt_pkg::ST_ZERO;
          end else begin
            out_d.status     = srt_pkg::ST_LOADED;
            out_d.process_id = srt_pkg::PID_W'(32'(loaded_q) + 32'd1);
            arr_we           = 1'b1;
            rem_we           = 1'b1;
            rem_waddr        = loaded_q[srt_pkg::SLOT_W-1:0];
            rem_wdata        = item_q.burst_length;
            done_d[loaded_q[srt_pkg::SLOT_W-1:0]] = 1'b0;
            loaded_d         = loaded_q + 1'b1;
          end
          out_d.all_done = (done_cnt_q == loaded_d);
          state_d        = S_IDLE;
        end
      end
      S_SCAN: begin
        if (issue) begin
          idx_d    = idx_q + 1'b1;
          rd_v_d   = 1'b1;
          rd_idx_d = idx_q[srt_pkg::SLOT_W-1:0];
        end
        if (rd_v_q && eligible && (!found_q || (rem_rd < best_rem_q))) begin
          found_d    = 1'b1;
          best_d     = rd_idx_q;
          best_rem_d = rem_rd;
        end
        if (!issue && !rd_v_q) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.tick_time = now_q;
          if (found_q) begin
            rem_we           = 1'b1;
            out_d.status     = srt_pkg::ST_RAN;
            out_d.process_id = srt_pkg::PID_W'(32'(best_q) + 32'd1);
          end else begin
            out_d.status     = srt_pkg::ST_IDLE;
            out_d.process_id = '0;
          end
          if (fin) begin
            done_d[best_q] = 1'b1;
            done_cnt_d     = done_cnt_q + 1'b1;
          end
          out_d.finished = fin;
          out_d.all_done = (done_cnt_d == loaded_q);
          if (now_q != '1) begin
            now_d = now_q + 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_q       <= '0;
      loaded_q    <= '0;
      done_cnt_q  <= '0;
      done_q      <= '0;
      idx_q       <= '0;
      rd_v_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      loaded_q    <= loaded_d;
      done_cnt_q  <= done_cnt_d;
      done_q      <= done_d;
      idx_q       <= idx_d;
      rd_v_q      <= rd_v_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    rd_idx_q   <= rd_idx_d;
    best_q     <= best_d;
    best_rem_q <= best_rem_d;
    out_q      <= out_d;
  end

endmodule

### hdl/srt_ram.sv
// generic single write port ram with registered read
module srt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### dv/srt_schedule_checker.sv
// transaction monitor, scheduling predictor and result comparison for the srt scheduler
`timescale 1ns / 1ps

module srt_schedule_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  srt_pkg::srt_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  srt_pkg::srt_out_t out_data_i,
  output int                outstanding_o,
  output int                errors_o
);

  logic [srt_pkg::TIME_W-1:0]  slot_arrival [srt_pkg::SLOTS];
  logic [srt_pkg::BURST_W-1:0] slot_left [srt_pkg::SLOTS];
  bit                          slot_done [srt_pkg::SLOTS];
  int unsigned                 n_loaded;
  int unsigned                 n_done;
  logic [srt_pkg::TIME_W-1:0]  clock_now;
  srt_pkg::srt_out_t           expected_results [$];

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t mismatch on %s: got %0h expected %0h", $time, what, got, want);
    errors_o++;
  endtask

  function automatic srt_pkg::srt_out_t schedule_step(input srt_pkg::srt_in_t item);
    srt_pkg::srt_out_t res;
    int                best;
    res = '0;
    res.tick_time = clock_now;
    if (item.kind == srt_pkg::KIND_LOAD) begin
      if (n_loaded >= srt_pkg::SLOTS) begin
        res.status = srt_pkg::ST_FULL;
      end else if (item.burst_length == '0) begin
        res.status = srt_pkg::ST_ZERO;
      end else begin
        slot_arrival[n_loaded] = item.arrival_time;
        slot_left[n_loaded] = item.burst_length;
        slot_done[n_loaded] = 1'b0;
        n_loaded++;
        res.status = srt_pkg::ST_LOADED;
        res.process_id = srt_pkg::PID_W'(n_loaded);
      end
    end else begin
      best = -1;
      for (int i = 0; i < int'(n_loaded); i++) begin
        if (!slot_done[i] && slot_arrival[i] <= clock_now) begin
          if (best < 0 || slot_left[i] < slot_left[best]) begin
            best = i;
          end
        end
      end
      if (best < 0) begin
        res.status = srt_pkg::ST_IDLE;
      end else begin
        res.status = srt_pkg::ST_RAN;
        res.process_id = srt_pkg::PID_W'(best + 1);
        if (slot_left[best] != '0) begin
          slot_left[best]--;
        end
        if (slot_left[best] == '0) begin
          slot_done[best] = 1'b1;
          n_done++;
          res.finished = 1'b1;
        end
      end
      if (clock_now != '1) begin
        clock_now++;
      end
    end
    res.all_done = (n_done == n_loaded);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    srt_pkg::srt_out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < srt_pkg::SLOTS; i++) begin
        slot_done[i] = 1'b0;
      end
      n_loaded = 0;
      n_done = 0;
      clock_now = '0;
      expected_results.delete();
      outstanding_o = 0;
      errors_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(schedule_step(in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_data_i, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.status !== want.status) begin
            report_mismatch("status", out_data_i.status, want.status);
          end
          if (out_data_i.tick_time !== want.tick_time) begin
            report_mismatch("tick_time", out_data_i.tick_time, want.tick_time);
          end
          if (out_data_i.process_id !== want.process_id) begin
            report_mismatch("process_id", out_data_i.process_id, want.process_id);
          end
          if (out_data_i.finished !== want.finished) begin
            report_mismatch("finished", out_data_i.finished, want.finished);
          end
          if (out_data_i.all_done !== want.all_done) begin
            report_mismatch("all_done", out_data_i.all_done, want.all_done);
          end
        end
      end
      outstanding_o = expected_results.size();
    end
  end

endmodule

### dv/testbench.sv
// stimulus, handshake pacing and verdict for the srt scheduler testbench
`timescale 1ns / 1ps

module testbench;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  srt_pkg::srt_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  srt_pkg::srt_out_t out_data;
  int                outstanding;
  int                errors;

  int unsigned ticks_sent = 0;
  int unsigned slots_used = 0;
  int unsigned items_sent = 0;
  bit          tx_eager = 1'b0;
  bit          rx_eager = 1'b0;

  shortest_remaining_time_scheduler DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  srt_schedule_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .outstanding_o (outstanding),
    .errors_o      (errors)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #1000000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_item(input logic kind, input logic [srt_pkg::TIME_W-1:0] arrival,
                           input logic [srt_pkg::BURST_W-1:0] burst);
    int               gap;
    srt_pkg::srt_in_t item;
    gap = tx_eager ? 0 : $urandom_range(0, 4);
    item.kind = kind;
    item.arrival_time = arrival;
    item.burst_length = burst;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    if (kind == srt_pkg::KIND_TICK) begin
      ticks_sent++;
    end else if (burst != '0 && slots_used < srt_pkg::SLOTS) begin
      slots_used++;
    end
    items_sent++;
    if (items_sent % 100 == 0) begin
      tx_eager = ($urandom_range(0, 2) == 0);
    end
  endtask

  task automatic send_tick();
    send_item(srt_pkg::KIND_TICK, $urandom, srt_pkg::BURST_W'($urandom));
  endtask

  // receiver pacing, with one long hold-off to back the block up
  initial begin : result_sink
    int gap;
    int taken;
    taken = 0;
    wait (rst_n);
    @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      do @(posedge clk); while (!(out_ready && out_valid));
      taken++;
      if (taken % 100 == 0) begin
        rx_eager = ($urandom_range(0, 2) == 0);
      end
      if (taken == 300) begin
        gap = 300;
      end else begin
        gap = rx_eager ? 0 : $urandom_range(0, 4);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : job_source
    logic [srt_pkg::BURST_W-1:0] burst;
    logic [srt_pkg::TIME_W-1:0]  arrival;
    wait (rst_n);
    @(posedge clk);

    // empty table: idle tick, zero burst, then ties and preemption
    send_item(srt_pkg::KIND_TICK, '1, '1);
    send_item(srt_pkg::KIND_LOAD, 32'd5, '0);
    send_item(srt_pkg::KIND_LOAD, 32'd0, 16'd3);
    send_item(srt_pkg::KIND_LOAD, 32'd0, 16'd3);
    send_item(srt_pkg::KIND_LOAD, 32'd2, 16'd1);
    repeat (7) send_tick();
    send_item(srt_pkg::KIND_LOAD, ticks_sent + 2, 16'd4);
    repeat (3) send_tick();
    send_item(srt_pkg::KIND_LOAD, 32'd0, 16'd1);
    repeat (4) send_tick();

    // well-formed arrivals with small bursts, table kept below full
    repeat (800) begin
      if ($urandom_range(0, 11) == 0 && slots_used < srt_pkg::SLOTS - 2) begin
        burst = ($urandom_range(0, 6) == 0) ? '0 :
                srt_pkg::BURST_W'($urandom_range(1, 15));
        if ($urandom_range(0, 3) == 0) begin
          arrival = $urandom_range(0, ticks_sent);
        end else begin
          arrival = ticks_sent + $urandom_range(0, 40);
        end
        send_item(srt_pkg::KIND_LOAD, arrival, burst);
      end else begin
        send_tick();
      end
    end

    // extreme entries, then a full table under random loads
    send_item(srt_pkg::KIND_LOAD, '1, '1);
    send_item(srt_pkg::KIND_LOAD, '0, '1);
    repeat (400) begin
      if ($urandom_range(0, 9) < 3) begin
        burst = ($urandom_range(0, 3) == 0) ? '0 : srt_pkg::BURST_W'($urandom);
        send_item(srt_pkg::KIND_LOAD, $urandom, burst);
      end else begin
        send_tick();
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (outstanding == 0);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
